>>> rtl/core/utok_pkg.sv
// Shared types and constants of the URI stream tokenizer.
`timescale 1ns / 1ps

package utok_pkg;

    // URI part codes
    localparam logic [2:0] PART_SCHEME = 3'd0;
    localparam logic [2:0] PART_AUTH   = 3'd1;
    localparam logic [2:0] PART_PATH   = 3'd2;
    localparam logic [2:0] PART_QUERY  = 3'd3;
    localparam logic [2:0] PART_FRAG   = 3'd4;

    // characters the tokenizer looks at
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_QUEST = "?";
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_AT    = "@";
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_LO_A  = "a";
    localparam logic [7:0] CH_LO_F  = "f";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // bundle queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int NRES   = 3;

    // escape decoder phase
    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HEX  = 3'b100
    } t_esc;

    // progress past the scheme terminator
    typedef enum logic [3:0] {
        SL_SCHEME = 4'b0001,
        SL_ENDED  = 4'b0010,
        SL_HELD   = 4'b0100,
        SL_DONE   = 4'b1000
    } t_slash;

    // one tagged output character
    typedef struct packed {
        logic [7:0] chr;
        logic [2:0] part;
        logic       sep;
    } t_entry;

    // all results caused by one input beat
    typedef struct packed {
        t_entry [NRES-1:0] ent;
        logic [1:0]        cnt;
        logic              last;
    } t_bundle;

    // front to queue write side
    typedef struct packed {
        logic    push;
        t_bundle data;
    } t_qwr;

    // queue head to back end
    typedef struct packed {
        logic    valid;
        t_bundle data;
    } t_qrd;

endpackage

>>> rtl/core/uri_stream_tokenizer_unit.sv
// Top level of the URI stream tokenizer.
`timescale 1ns / 1ps

// Takes a URI one byte per beat (in_last on its final byte) and returns tagged
// characters: each carries its URI part (0 scheme, 1 authority, 2 path, 3 query,
// 4 fragment) and a separator flag. Input is lowercased, percent escapes are
// decoded unless they decode to a reserved character or hold a bad hex digit,
// in which case the three raw bytes pass as content. The front end accepts one
// byte every cycle while the queue is not full and turns it into a bundle of
// zero to three results in that cycle; bundles wait in a four-entry queue and
// the output serializer delivers one result per cycle while the receiver is
// ready. Most bytes give one result, the '//' that opens the authority and a
// rejected escape give two or three, and the queue absorbs such bursts before
// input ready drops. The first result of a byte passes through the queue and
// the output register before it is presented on the output.
module uri_stream_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_part,
    output logic       o_is_separator,
    output logic       o_out_last
);
    import utok_pkg::*;

    t_qwr wr;
    t_qrd rd;
    logic full;
    logic pop;

    utok_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_full     (full),
        .o_wr       (wr)
    );

    utok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .i_pop   (pop),
        .o_rd    (rd)
    );

    utok_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd           (rd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_part         (o_part),
        .o_is_separator (o_is_separator),
        .o_out_last     (o_out_last)
    );

endmodule

>>> rtl/core/utok_front.sv
// Front end: lowercasing, escape decoding and part classification per input beat.
`timescale 1ns / 1ps

module utok_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_full,
    output utok_pkg::t_qwr o_wr
);
    import utok_pkg::*;

    typedef struct packed {
        t_entry     ent;
        logic [2:0] part;
    } t_cls;

    logic [2:0] r_part, n_part;
    t_esc       r_esc, n_esc;
    logic [7:0] r_fh, n_fh;
    t_slash     r_sp, n_sp;

    logic       accept;
    logic [7:0] c;
    logic [1:0] k;
    t_bundle    bun;
    t_cls       cls;
    logic [4:0] hx_hi, hx_lo;
    logic [7:0] dec;

    function automatic t_entry mk(input logic [7:0] ch, input logic [2:0] p, input logic s);
        t_entry e;
        e.chr  = ch;
        e.part = p;
        e.sep  = s;
        return e;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hexval(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'd0;
        if (ch >= CH_0 && ch <= CH_9) begin
            t = ch - CH_0;
            return {1'b1, t[3:0]};
        end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
            t = ch - CH_LO_A + HEX_TEN;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic reserved(input logic [7:0] v);
        logic r;
        case (v) inside
            ":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'", "(", ")",
            "*", "+", ",", ";", "=": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // delimiter handling once the scheme is settled
    function automatic t_cls classify(input logic [7:0] ch, input logic [2:0] p);
        t_cls o;
        o.part = p;
        o.ent  = mk(ch, p, 1'b0);
        if (p == PART_AUTH || p == PART_PATH) begin
            if (ch == CH_SLASH) begin
                o.part = PART_PATH;
                o.ent  = mk(ch, PART_PATH, 1'b1);
            end else if (ch == CH_QUEST) begin
                o.part = PART_QUERY;
                o.ent  = mk(ch, PART_QUERY, 1'b1);
            end else if (ch == CH_HASH) begin
                o.part = PART_FRAG;
                o.ent  = mk(ch, PART_FRAG, 1'b1);
            end else if (p == PART_AUTH && (ch == CH_AT || ch == CH_COLON)) begin
                o.ent  = mk(ch, PART_AUTH, 1'b1);
            end
        end else if (p == PART_QUERY) begin
            if (ch == CH_HASH) begin
                o.part = PART_FRAG;
                o.ent  = mk(ch, PART_FRAG, 1'b1);
            end else begin
                o.ent  = mk(ch, PART_QUERY, (ch == CH_AMP || ch == CH_EQ));
            end
        end
        return o;
    endfunction

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    assign c     = (i_in_byte >= CH_UP_A && i_in_byte <= CH_UP_Z) ? i_in_byte + CASE_OFS
                                                                  : i_in_byte;
    assign hx_hi = hexval(r_fh);
    assign hx_lo = hexval(c);
    assign dec   = {hx_hi[3:0], hx_lo[3:0]};

    // results and next state for the beat on the input
    always_comb begin
        n_part = r_part;
        n_esc  = r_esc;
        n_fh   = r_fh;
        n_sp   = r_sp;
        bun    = '0;
        k      = 2'd0;
        cls    = '0;
        unique case (r_esc)
            ESC_IDLE: begin
                if (c == CH_PCT) begin
                    if (r_sp == SL_HELD) begin
                        bun.ent[k] = mk(CH_SLASH, PART_PATH, 1'b1);
                        k      = k + 2'd1;
                        n_part = PART_PATH;
                        n_sp   = SL_DONE;
                    end else if (r_sp == SL_ENDED) begin
                        n_sp = SL_DONE;
                    end
                    n_esc = ESC_PCT;
                    if (i_in_last) begin
                        bun.ent[k] = mk(CH_PCT, n_part, 1'b0);
                        k = k + 2'd1;
                    end
                end else begin
                    unique case (r_sp)
                        SL_SCHEME: begin
                            if (c == CH_COLON || c == CH_SLASH || c == CH_QUEST
                                || c == CH_HASH) begin
                                bun.ent[k] = mk(c, PART_SCHEME, 1'b1);
                                n_sp   = SL_ENDED;
                                n_part = PART_PATH;
                            end else begin
                                bun.ent[k] = mk(c, PART_SCHEME, 1'b0);
                            end
                            k = k + 2'd1;
                        end
                        SL_ENDED: begin
                            if (c == CH_SLASH) begin
                                n_sp = SL_HELD;
                            end else begin
                                n_sp       = SL_DONE;
                                cls        = classify(c, r_part);
                                n_part     = cls.part;
                                bun.ent[k] = cls.ent;
                                k          = k + 2'd1;
                            end
                        end
                        SL_HELD: begin
                            n_sp = SL_DONE;
                            if (c == CH_SLASH) begin
                                bun.ent[k] = mk(CH_SLASH, PART_AUTH, 1'b1);
                                k          = k + 2'd1;
                                bun.ent[k] = mk(CH_SLASH, PART_AUTH, 1'b1);
                                k          = k + 2'd1;
                                n_part     = PART_AUTH;
                            end else begin
                                bun.ent[k] = mk(CH_SLASH, PART_PATH, 1'b1);
                                k          = k + 2'd1;
                                cls        = classify(c, PART_PATH);
                                n_part     = cls.part;
                                bun.ent[k] = cls.ent;
                                k          = k + 2'd1;
                            end
                        end
                        SL_DONE: begin
                            cls        = classify(c, r_part);
                            n_part     = cls.part;
                            bun.ent[k] = cls.ent;
                            k          = k + 2'd1;
                        end
                        default: ;
                    endcase
                    // held slash flushed at end of URI
                    if (i_in_last && n_sp == SL_HELD) begin
                        bun.ent[k] = mk(CH_SLASH, PART_PATH, 1'b1);
                        k = k + 2'd1;
                    end
                end
            end
            ESC_PCT: begin
                n_fh  = c;
                n_esc = ESC_HEX;
                if (i_in_last) begin
                    bun.ent[k] = mk(CH_PCT, r_part, 1'b0);
                    k          = k + 2'd1;
                    bun.ent[k] = mk(c, r_part, 1'b0);
                    k          = k + 2'd1;
                end
            end
            ESC_HEX: begin
                n_esc = ESC_IDLE;
                n_fh  = 8'd0;
                if (hx_hi[4] && hx_lo[4] && !reserved(dec)) begin
                    bun.ent[k] = mk(dec, r_part, 1'b0);
                    k          = k + 2'd1;
                end else begin
                    // bad or reserved escape passes through as three bytes
                    bun.ent[k] = mk(CH_PCT, r_part, 1'b0);
                    k          = k + 2'd1;
                    bun.ent[k] = mk(r_fh, r_part, 1'b0);
                    k          = k + 2'd1;
                    bun.ent[k] = mk(c, r_part, 1'b0);
                    k          = k + 2'd1;
                end
            end
            default: ;
        endcase
        bun.cnt  = k;
        bun.last = i_in_last;
        // end of URI returns to the reset state
        if (i_in_last) begin
            n_part = PART_SCHEME;
            n_esc  = ESC_IDLE;
            n_fh   = 8'd0;
            n_sp   = SL_SCHEME;
        end
    end

    assign o_wr.push = accept && (k != 2'd0);
    assign o_wr.data = bun;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= PART_SCHEME;
            r_esc  <= ESC_IDLE;
            r_fh   <= 8'd0;
            r_sp   <= SL_SCHEME;
        end else if (accept) begin
            r_part <= n_part;
            r_esc  <= n_esc;
            r_fh   <= n_fh;
            r_sp   <= n_sp;
        end
    end

endmodule

>>> rtl/core/utok_queue.sv
// Bundle queue between the front end and the output serializer.
`timescale 1ns / 1ps

module utok_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  utok_pkg::t_qwr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output utok_pkg::t_qrd o_rd
);
    import utok_pkg::*;

    t_bundle          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_full      = (r_cnt == QDEPTH[QAW:0]);
    assign o_rd.valid  = (r_cnt != '0);
    assign o_rd.data   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wp] <= i_wr.data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (i_wr.push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

`ifndef SYNTH
    // front must hold off when the queue is full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("bundle pushed into full queue");

    // back end pops only a present bundle
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_rd.valid)
        else $error("bundle popped from empty queue");

    // fill count tracks the pointers
    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == r_cnt[QAW-1:0])
        else $error("queue count out of step with pointers");

    // a stored bundle always carries at least one result
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd.valid |-> (o_rd.data.cnt != 2'd0))
        else $error("empty bundle in queue");
`endif

endmodule

>>> rtl/core/utok_back.sv
// Back end: serializes queued bundles, one registered output beat per ready cycle.
`timescale 1ns / 1ps

module utok_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  utok_pkg::t_qrd i_rd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic [2:0]     o_part,
    output logic           o_is_separator,
    output logic           o_out_last
);
    import utok_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_entry     r_ent;
    logic       r_last;

    logic       load;
    logic       at_end;

    assign load   = !r_valid || i_out_ready;
    assign at_end = (r_idx == i_rd.data.cnt - 2'd1);
    assign o_pop  = load && i_rd.valid && at_end;

    // output register, refilled whenever it is empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_rd.valid;
            if (i_rd.valid) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_rd.valid) begin
            r_ent  <= i_rd.data.ent[r_idx];
            r_last <= i_rd.data.last && at_end;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_ent.chr;
    assign o_part         = r_ent.part;
    assign o_is_separator = r_ent.sep;
    assign o_out_last     = r_last;

endmodule

>>> sim/tb_uri_stream_tokenizer_unit.sv
// Self-checking testbench for the URI stream tokenizer: directed URIs, then random ones.
`timescale 1ns / 1ps

module tb_uri_stream_tokenizer_unit;
    import utok_pkg::*;

    // one tagged character as the block should deliver it
    typedef struct packed {
        logic [7:0] chr;
        logic [2:0] part;
        logic       sep;
        logic       last;
    } t_token;

    // escapes decoding to one of these pass through raw
    localparam logic [7:0] RESERVED_SET [18] = '{
        CH_COLON, CH_SLASH, CH_QUEST, CH_HASH, "[", "]", CH_AT, "!", "$",
        CH_AMP, "'", "(", ")", "*", "+", ",", ";", CH_EQ
    };
    localparam string UNRESERVED = "-._~";

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = '0;
    logic       i_in_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic [2:0] o_part;
    logic       o_is_separator;
    logic       o_out_last;

    // tokenizer state mirror
    logic [2:0] cur_part;
    t_esc       esc_state;
    logic [7:0] held_digit;
    t_slash     slash_state;

    t_token     expected_tokens[$];
    t_token     step_tokens[$];
    logic [7:0] uri_text[$];
    int         mismatch_count = 0;

    // idling controls
    bit         send_gaps = 1'b0;
    bit         recv_gaps = 1'b0;
    int         stall_left = 0;

    uri_stream_tokenizer_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_part         (o_part),
        .o_is_separator (o_is_separator),
        .o_out_last     (o_out_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tokenizer prediction
    // ------------------------------------------------------------------

    function automatic void reset_tokenizer();
        cur_part    = PART_SCHEME;
        esc_state   = ESC_IDLE;
        held_digit  = '0;
        slash_state = SL_SCHEME;
    endfunction

    // at most three results per input beat
    function automatic void emit_token(input logic [7:0] c, input logic [2:0] p,
                                       input logic s);
        t_token t;
        if (step_tokens.size() >= NRES) return;
        t.chr  = c;
        t.part = p;
        t.sep  = s;
        t.last = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic bit is_reserved_char(input logic [7:0] v);
        foreach (RESERVED_SET[i])
            if (RESERVED_SET[i] == v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + int'(HEX_TEN);
        return -1;
    endfunction

    // anything but a slash after the scheme decides authority vs path
    function automatic void settle_authority();
        if (slash_state == SL_HELD) begin
            emit_token(CH_SLASH, PART_PATH, 1'b1);
            slash_state = SL_DONE;
            cur_part    = PART_PATH;
        end else if (slash_state == SL_ENDED) begin
            slash_state = SL_DONE;
        end
    endfunction

    function automatic void content_token(input logic [7:0] c);
        settle_authority();
        emit_token(c, cur_part, 1'b0);
    endfunction

    function automatic void structural_token(input logic [7:0] c);
        if (slash_state == SL_SCHEME) begin
            if (c == CH_COLON || c == CH_SLASH || c == CH_QUEST || c == CH_HASH) begin
                emit_token(c, PART_SCHEME, 1'b1);
                slash_state = SL_ENDED;
                cur_part    = PART_PATH;
            end else begin
                emit_token(c, PART_SCHEME, 1'b0);
            end
            return;
        end
        if (slash_state == SL_ENDED && c == CH_SLASH) begin
            slash_state = SL_HELD;
            return;
        end
        if (slash_state == SL_HELD && c == CH_SLASH) begin
            emit_token(CH_SLASH, PART_AUTH, 1'b1);
            emit_token(CH_SLASH, PART_AUTH, 1'b1);
            slash_state = SL_DONE;
            cur_part    = PART_AUTH;
            return;
        end
        settle_authority();
        case (cur_part)
            PART_AUTH, PART_PATH: begin
                if (c == CH_SLASH) begin
                    cur_part = PART_PATH;
                    emit_token(c, PART_PATH, 1'b1);
                end else if (c == CH_QUEST) begin
                    cur_part = PART_QUERY;
                    emit_token(c, PART_QUERY, 1'b1);
                end else if (c == CH_HASH) begin
                    cur_part = PART_FRAG;
                    emit_token(c, PART_FRAG, 1'b1);
                end else if (cur_part == PART_AUTH && (c == CH_AT || c == CH_COLON)) begin
                    emit_token(c, PART_AUTH, 1'b1);
                end else begin
                    emit_token(c, cur_part, 1'b0);
                end
            end
            PART_QUERY: begin
                if (c == CH_HASH) begin
                    cur_part = PART_FRAG;
                    emit_token(c, PART_FRAG, 1'b1);
                end else begin
                    emit_token(c, PART_QUERY, c == CH_AMP || c == CH_EQ);
                end
            end
            default: emit_token(c, cur_part, 1'b0);
        endcase
    endfunction

    // expected results of one accepted input beat
    function automatic void predict_beat(input logic [7:0] raw, input logic last);
        logic [7:0] c;
        logic [7:0] v;
        int         hi;
        int         lo;
        step_tokens.delete();
        c = raw;
        if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;

        case (esc_state)
            ESC_IDLE: begin
                if (c == CH_PCT) begin
                    settle_authority();
                    esc_state = ESC_PCT;
                end else begin
                    structural_token(c);
                end
            end
            ESC_PCT: begin
                held_digit = c;
                esc_state  = ESC_HEX;
            end
            default: begin
                hi        = hex_nibble(held_digit);
                lo        = hex_nibble(c);
                esc_state = ESC_IDLE;
                v         = 8'(hi * 16 + lo);
                if (hi < 0 || lo < 0 || is_reserved_char(v)) begin
                    content_token(CH_PCT);
                    content_token(held_digit);
                    content_token(c);
                end else begin
                    content_token(v);
                end
                held_digit = '0;
            end
        endcase

        // flush whatever is pending at the end of the URI
        if (last) begin
            if (esc_state == ESC_PCT) begin
                content_token(CH_PCT);
            end else if (esc_state == ESC_HEX) begin
                content_token(CH_PCT);
                content_token(held_digit);
            end
            if (slash_state == SL_HELD) emit_token(CH_SLASH, PART_PATH, 1'b1);
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            reset_tokenizer();
        end
        foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // one beat; called at a rising edge, returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (send_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_beat(b, last);
    endtask

    task automatic send_uri_text();
        foreach (uri_text[i]) send_byte(uri_text[i], i == uri_text.size() - 1);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    // append one byte to the URI under construction
    function automatic void add_byte(input logic [7:0] b);
        uri_text.insert(uri_text.size(), b);
    endfunction

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // ------------------------------------------------------------------
    // Random URI text
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + 8'(n);
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(n) - HEX_TEN;
    endfunction

    function automatic logic [7:0] random_letter();
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'($urandom_range(0, 25));
    endfunction

    function automatic void add_escape();
        logic [7:0] v;
        add_byte(CH_PCT);
        case ($urandom_range(0, 2))
            0: v = 8'($urandom_range(0, 255));
            1: v = RESERVED_SET[$urandom_range(0, 17)];
            default: begin
                // random byte, usually not a hex digit, in either position
                if ($urandom_range(0, 1)) begin
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(hex_char(4'($urandom_range(0, 15))));
                end else begin
                    add_byte(hex_char(4'($urandom_range(0, 15))));
                    add_byte(8'($urandom_range(0, 255)));
                end
                return;
            end
        endcase
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    function automatic void add_content(input int n);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_byte(random_letter());
                5, 6: add_byte(CH_0 + 8'($urandom_range(0, 9)));
                7: add_byte(UNRESERVED[$urandom_range(0, 3)]);
                8: add_escape();
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // mostly well-formed URIs, some noise and some cut short
    function automatic void build_random_uri();
        int kind;
        int cut;
        uri_text.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 4)) add_byte(random_letter());
        case ($urandom_range(0, 7))
            0: add_byte(CH_SLASH);
            1: add_byte(CH_QUEST);
            2: add_byte(CH_HASH);
            default: add_byte(CH_COLON);
        endcase
        if ($urandom_range(0, 2) != 0) begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            add_content($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) begin
                add_byte(CH_AT);
                add_content($urandom_range(1, 3));
            end
            if ($urandom_range(0, 2) == 0) begin
                add_byte(CH_COLON);
                repeat ($urandom_range(1, 3)) add_byte(CH_0 + 8'($urandom_range(0, 9)));
            end
        end else if ($urandom_range(0, 1)) begin
            add_byte(CH_SLASH);
        end
        repeat ($urandom_range(0, 3)) begin
            add_byte(CH_SLASH);
            add_content($urandom_range(0, 3));
        end
        if ($urandom_range(0, 1)) begin
            add_byte(CH_QUEST);
            repeat ($urandom_range(1, 2)) begin
                add_content($urandom_range(1, 2));
                add_byte(CH_EQ);
                add_content($urandom_range(0, 2));
                if ($urandom_range(0, 1)) add_byte(CH_AMP);
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            add_byte(CH_HASH);
            add_content($urandom_range(0, 3));
        end
        // broken: URI ends early, possibly inside an escape or on a slash
        if (kind == 1 && uri_text.size() > 1) begin
            cut = $urandom_range(1, uri_text.size() - 1);
            while (uri_text.size() > cut) void'(uri_text.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // receiver drops ready in random bursts while recv_gaps is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                $error("unexpected result: out_byte %h part %0d", o_out_byte, o_part);
            end else begin
                want = expected_tokens.pop_front();
                if (o_out_byte !== want.chr) begin
                    mismatch_count++;
                    $error("out_byte: expected %h, got %h", want.chr, o_out_byte);
                end
                if (o_part !== want.part) begin
                    mismatch_count++;
                    $error("part: expected %0d, got %0d", want.part, o_part);
                end
                if (o_is_separator !== want.sep) begin
                    mismatch_count++;
                    $error("is_separator: expected %b, got %b", want.sep, o_is_separator);
                end
                if (o_out_last !== want.last) begin
                    mismatch_count++;
                    $error("out_last: expected %b, got %b", want.last, o_out_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every structural mark, plus byte extremes in scheme and query
    task automatic test_structure_marks();
        uri_text.delete();
        add_byte(8'hFF);
        append_text("://@:/?=&");
        add_byte(8'h00);
        append_text("#");
        send_uri_text();
    endtask

    // reserved escape, bad hex digit, decoded upper-case value
    task automatic test_escapes();
        uri_text.delete();
        append_text("?%2f%G1%4A");
        send_uri_text();
    endtask

    // single slash after the scheme, and URIs ending mid-escape or on a held slash
    task automatic test_open_endings();
        uri_text.delete();
        append_text(":/A%4");
        send_uri_text();
        uri_text.delete();
        append_text("/%");
        send_uri_text();
        uri_text.delete();
        append_text("#/");
        send_uri_text();
    endtask

    // sender holds off until the block has delivered everything
    task automatic test_drain_pause();
        wait_for_drain();
    endtask

    task automatic test_random_uris(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_random_uri();
            send_uri_text();
            sent += uri_text.size();
        end
    endtask

    initial begin
        reset_tokenizer();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_structure_marks();
        test_escapes();
        test_open_endings();
        test_drain_pause();

        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        test_random_uris(120);
        test_drain_pause();

        send_gaps = 1'b0;
        test_random_uris(50);

        send_gaps = 1'b1;
        recv_gaps = 1'b0;
        test_random_uris(50);

        // closing stretch at full rate on both sides
        send_gaps = 1'b0;
        test_random_uris(90);

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_uri_stream_tokenizer_unit: done, clean");
        else
            $display("tb_uri_stream_tokenizer_unit: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("tb_uri_stream_tokenizer_unit: done, errors");
        $finish;
    end

endmodule
